@@ rtl/hsv_to_rgb_converter_top_defines.svh @@
// Assertion macros shared by the HSV to RGB converter RTL.
// Depends on nothing; included by the modules that check their own pipelines.
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// Checks that expr holds in the same cycle whenever cond holds.
`define HSV2RGB_ASSERT_HOLDS(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Checks that expr holds after the delay n whenever cond holds.
`define HSV2RGB_ASSERT_DELAY(label, clk, rst_n, cond, n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##n (expr)) \
        else $error(msg);

`endif

@@ rtl/hsv2rgb_pkg.sv @@
// Shared constants, sector codes and inter-stage structs for the HSV to RGB converter.
// Depends on nothing; imported by every module of the converter.
package hsv2rgb_pkg;

    localparam int HUE_W      = 16;
    localparam int CHAN_W     = 8;
    localparam int HUE_TURN   = 23040;
    localparam int HUE_SECTOR = 3840;
    localparam int FRAC_ONE   = 255;
    localparam int MOD_W      = 15;
    localparam int REM_W      = 12;

    localparam int LEVEL_DEN  = FRAC_ONE * HUE_SECTOR;
    localparam int PROD_W     = 2 * CHAN_W + REM_W;

    localparam int QT_NUM_W   = PROD_W + 1;
    localparam int QT_DIVISOR = 2 * LEVEL_DEN;
    localparam int QT_SHIFT   = 32;
    localparam longint unsigned QT_RECIP = (64'd1 << QT_SHIFT) / QT_DIVISOR;

    localparam int P_NUM_W    = 2 * CHAN_W + 1;
    localparam int P_DIVISOR  = 2 * FRAC_ONE;
    localparam int P_SHIFT    = 24;
    localparam longint unsigned P_RECIP = (64'd1 << P_SHIFT) / P_DIVISOR;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        logic              valid;
        sector_t           sector;
        logic [REM_W-1:0]  rem;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
    } split_t;

    typedef struct packed {
        logic              valid;
        sector_t           sector;
        logic [CHAN_W-1:0] val;
        logic [CHAN_W-1:0] p;
        logic [CHAN_W-1:0] q;
        logic [CHAN_W-1:0] t;
    } level_t;

endpackage

@@ rtl/hsv2rgb_const_div.sv @@
// Two-stage rounding-free divider by a constant: reciprocal estimate, then one correction.
// Depends on hsv2rgb_pkg for the quotient width.
module hsv2rgb_const_div
    import hsv2rgb_pkg::*;
#(
    parameter int              NUM_W   = QT_NUM_W,
    parameter int              DIVISOR = QT_DIVISOR,
    parameter longint unsigned RECIP   = QT_RECIP,
    parameter int              SHIFT   = QT_SHIFT
)
(
    input  logic              clk,
    input  logic [NUM_W-1:0]  num,
    output logic [CHAN_W-1:0] quot
);

    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int MUL_W   = NUM_W + RECIP_W;
    localparam int DIV_W   = $clog2(DIVISOR + 1);
    localparam int BACK_W  = CHAN_W + DIV_W;

    logic [MUL_W-1:0]  prod;
    logic [CHAN_W-1:0] est_next;
    logic [CHAN_W-1:0] est_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [BACK_W-1:0] back;
    logic [NUM_W-1:0]  rem;
    logic [CHAN_W-1:0] quot_next;
    logic [CHAN_W-1:0] quot_reg;

    assign prod     = MUL_W'(num) * MUL_W'(RECIP);
    assign est_next = prod[SHIFT +: CHAN_W];

    always_ff @(posedge clk)
    begin
        est_reg <= est_next;
        num_reg <= num;
    end

    assign back      = BACK_W'(est_reg) * BACK_W'(DIVISOR);
    assign rem       = num_reg - NUM_W'(back);
    assign quot_next = (rem >= NUM_W'(DIVISOR)) ? est_reg + CHAN_W'(1) : est_reg;

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

@@ rtl/hsv2rgb_hue_split.sv @@
// Hue front end: reduces the hue modulo a full turn, then splits it into sector and remainder.
// Depends on hsv2rgb_pkg and the assertion macros header.
`include "hsv_to_rgb_converter_top_defines.svh"

module hsv2rgb_hue_split
    import hsv2rgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [HUE_W-1:0]  hue,
    input  logic [CHAN_W-1:0] saturation,
    input  logic [CHAN_W-1:0] brightness,
    output split_t            split
);

    logic              valid1_reg;
    logic [MOD_W-1:0]  mod_next;
    logic [MOD_W-1:0]  mod_reg;
    logic [CHAN_W-1:0] sat1_reg;
    logic [CHAN_W-1:0] val1_reg;
    logic              valid2_reg;
    sector_t           sector_next;
    sector_t           sector_reg;
    logic [MOD_W-1:0]  base;
    logic [REM_W-1:0]  rem_next;
    logic [REM_W-1:0]  rem_reg;
    logic [CHAN_W-1:0] sat2_reg;
    logic [CHAN_W-1:0] val2_reg;

    always_comb
    begin
        if (hue >= HUE_W'(2 * HUE_TURN))
        begin
            mod_next = MOD_W'(hue - HUE_W'(2 * HUE_TURN));
        end
        else if (hue >= HUE_W'(HUE_TURN))
        begin
            mod_next = MOD_W'(hue - HUE_W'(HUE_TURN));
        end
        else
        begin
            mod_next = MOD_W'(hue);
        end
    end

    always_comb
    begin
        if (mod_reg >= MOD_W'(5 * HUE_SECTOR))
        begin
            sector_next = SEC_MAGENTA;
            base        = MOD_W'(5 * HUE_SECTOR);
        end
        else if (mod_reg >= MOD_W'(4 * HUE_SECTOR))
        begin
            sector_next = SEC_BLUE;
            base        = MOD_W'(4 * HUE_SECTOR);
        end
        else if (mod_reg >= MOD_W'(3 * HUE_SECTOR))
        begin
            sector_next = SEC_CYAN;
            base        = MOD_W'(3 * HUE_SECTOR);
        end
        else if (mod_reg >= MOD_W'(2 * HUE_SECTOR))
        begin
            sector_next = SEC_GREEN;
            base        = MOD_W'(2 * HUE_SECTOR);
        end
        else if (mod_reg >= MOD_W'(HUE_SECTOR))
        begin
            sector_next = SEC_YELLOW;
            base        = MOD_W'(HUE_SECTOR);
        end
        else
        begin
            sector_next = SEC_RED;
            base        = '0;
        end
        rem_next = REM_W'(mod_reg - base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg    <= mod_next;
        sat1_reg   <= saturation;
        val1_reg   <= brightness;
        sector_reg <= sector_next;
        rem_reg    <= rem_next;
        sat2_reg   <= sat1_reg;
        val2_reg   <= val1_reg;
    end

    assign split.valid  = valid2_reg;
    assign split.sector = sector_reg;
    assign split.rem    = rem_reg;
    assign split.sat    = sat2_reg;
    assign split.val    = val2_reg;

    `HSV2RGB_ASSERT_HOLDS(a_rem_in_sector, clk, rst_n, split.valid, split.rem < REM_W'(HUE_SECTOR), "Sector remainder out of range")
    `HSV2RGB_ASSERT_DELAY(a_split_valid, clk, rst_n, in_valid, 2, split.valid, "Hue split lost a word")

endmodule

@@ rtl/hsv2rgb_level_calc.sv @@
// Computes the rounded p, q and t levels from sector remainder, saturation and value.
// Depends on hsv2rgb_pkg, hsv2rgb_const_div and the assertion macros header.
`include "hsv_to_rgb_converter_top_defines.svh"

module hsv2rgb_level_calc
    import hsv2rgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  split_t split,
    output level_t levels
);

    localparam int VS_W = 2 * CHAN_W;

    logic              valid3_reg;
    logic              valid4_reg;
    logic              valid5_reg;
    logic              valid6_reg;
    logic              valid7_reg;
    sector_t           sector3_reg;
    sector_t           sector4_reg;
    sector_t           sector5_reg;
    sector_t           sector6_reg;
    sector_t           sector7_reg;
    logic [CHAN_W-1:0] val3_reg;
    logic [CHAN_W-1:0] val4_reg;
    logic [CHAN_W-1:0] val5_reg;
    logic [CHAN_W-1:0] val6_reg;
    logic [CHAN_W-1:0] val7_reg;

    logic [VS_W-1:0]     vs_reg;
    logic [VS_W-1:0]     vx_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    remc_reg;
    logic [PROD_W-1:0]   aq_reg;
    logic [PROD_W-1:0]   at_reg;
    logic [P_NUM_W-1:0]  np4_reg;
    logic [PROD_W-1:0]   vd;
    logic [PROD_W-1:0]   dq;
    logic [PROD_W-1:0]   dt;
    logic [QT_NUM_W-1:0] nq_reg;
    logic [QT_NUM_W-1:0] nt_reg;
    logic [P_NUM_W-1:0]  np5_reg;
    logic [CHAN_W-1:0]   p_quot;
    logic [CHAN_W-1:0]   q_quot;
    logic [CHAN_W-1:0]   t_quot;

    assign vd = PROD_W'(val4_reg) * PROD_W'(LEVEL_DEN);
    assign dq = vd - aq_reg;
    assign dt = vd - at_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
            valid6_reg <= 1'b0;
            valid7_reg <= 1'b0;
        end
        else
        begin
            valid3_reg <= split.valid;
            valid4_reg <= valid3_reg;
            valid5_reg <= valid4_reg;
            valid6_reg <= valid5_reg;
            valid7_reg <= valid6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vs_reg      <= VS_W'(split.val) * VS_W'(split.sat);
        vx_reg      <= VS_W'(split.val) * VS_W'(CHAN_W'(FRAC_ONE) - split.sat);
        rem_reg     <= split.rem;
        remc_reg    <= REM_W'(HUE_SECTOR) - split.rem;
        sector3_reg <= split.sector;
        val3_reg    <= split.val;

        aq_reg      <= PROD_W'(vs_reg) * PROD_W'(rem_reg);
        at_reg      <= PROD_W'(vs_reg) * PROD_W'(remc_reg);
        np4_reg     <= P_NUM_W'({vx_reg, 1'b0}) + P_NUM_W'(FRAC_ONE);
        sector4_reg <= sector3_reg;
        val4_reg    <= val3_reg;

        nq_reg      <= QT_NUM_W'({dq, 1'b0}) + QT_NUM_W'(LEVEL_DEN);
        nt_reg      <= QT_NUM_W'({dt, 1'b0}) + QT_NUM_W'(LEVEL_DEN);
        np5_reg     <= np4_reg;
        sector5_reg <= sector4_reg;
        val5_reg    <= val4_reg;

        sector6_reg <= sector5_reg;
        val6_reg    <= val5_reg;
        sector7_reg <= sector6_reg;
        val7_reg    <= val6_reg;
    end

    hsv2rgb_const_div #(
        .NUM_W   (P_NUM_W),
        .DIVISOR (P_DIVISOR),
        .RECIP   (P_RECIP),
        .SHIFT   (P_SHIFT)
    ) u_div_p (
        .clk  (clk),
        .num  (np5_reg),
        .quot (p_quot)
    );

    hsv2rgb_const_div #(
        .NUM_W   (QT_NUM_W),
        .DIVISOR (QT_DIVISOR),
        .RECIP   (QT_RECIP),
        .SHIFT   (QT_SHIFT)
    ) u_div_q (
        .clk  (clk),
        .num  (nq_reg),
        .quot (q_quot)
    );

    hsv2rgb_const_div #(
        .NUM_W   (QT_NUM_W),
        .DIVISOR (QT_DIVISOR),
        .RECIP   (QT_RECIP),
        .SHIFT   (QT_SHIFT)
    ) u_div_t (
        .clk  (clk),
        .num  (nt_reg),
        .quot (t_quot)
    );

    assign levels.valid  = valid7_reg;
    assign levels.sector = sector7_reg;
    assign levels.val    = val7_reg;
    assign levels.p      = p_quot;
    assign levels.q      = q_quot;
    assign levels.t      = t_quot;

    `HSV2RGB_ASSERT_HOLDS(a_levels_below_value, clk, rst_n, levels.valid, (levels.p <= levels.val) && (levels.q <= levels.val) && (levels.t <= levels.val), "Level exceeds value")
    `HSV2RGB_ASSERT_DELAY(a_levels_valid, clk, rst_n, split.valid, 5, levels.valid, "Level pipeline lost a word")

endmodule

@@ rtl/hsv_to_rgb_converter_top.sv @@
// HSV to RGB converter: accepts one word per cycle, busy is never raised.
// Output: done is high together with the registered result, after the hue split, level and divider stages.
// Throughput: one word per clock, set by the fully pipelined multiply and divide stages.
// Reset: rst_n clears all valid bits at once; no word is in flight after reset.
// Depends on hsv2rgb_pkg, hsv2rgb_hue_split, hsv2rgb_level_calc and the macros header.
`include "hsv_to_rgb_converter_top_defines.svh"

module hsv_to_rgb_converter_top
    import hsv2rgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [HUE_W-1:0]  hue,
    input  logic [CHAN_W-1:0] saturation,
    input  logic [CHAN_W-1:0] brightness,
    output logic              done,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue
);

    split_t            split;
    level_t            levels;
    logic              accept;
    logic              done_reg;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsv2rgb_hue_split u_hue_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .split      (split)
    );

    hsv2rgb_level_calc u_level_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .split  (split),
        .levels (levels)
    );

    always_comb
    begin
        case (levels.sector)
            SEC_RED:
            begin
                red_next   = levels.val;
                green_next = levels.t;
                blue_next  = levels.p;
            end
            SEC_YELLOW:
            begin
                red_next   = levels.q;
                green_next = levels.val;
                blue_next  = levels.p;
            end
            SEC_GREEN:
            begin
                red_next   = levels.p;
                green_next = levels.val;
                blue_next  = levels.t;
            end
            SEC_CYAN:
            begin
                red_next   = levels.p;
                green_next = levels.q;
                blue_next  = levels.val;
            end
            SEC_BLUE:
            begin
                red_next   = levels.t;
                green_next = levels.p;
                blue_next  = levels.val;
            end
            default:
            begin
                red_next   = levels.val;
                green_next = levels.p;
                blue_next  = levels.q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= levels.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    `HSV2RGB_ASSERT_DELAY(a_word_delivered, clk, rst_n, accept, 8, done, "Accepted word was not delivered")

endmodule

@@ verif/tb_hsv_to_rgb_converter_top.sv @@
// Testbench for hsv_to_rgb_converter_top: drives HSV words and checks every RGB result
// against a predictor kept in this file. Depends on hsv2rgb_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter_top
    import hsv2rgb_pkg::*;
();

    localparam int RANDOM_WORDS = 1500;
    localparam int TAIL_WORDS   = 200;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
    } hsv_word_t;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [HUE_W-1:0]  hue = '0;
    logic [CHAN_W-1:0] saturation = '0;
    logic [CHAN_W-1:0] brightness = '0;
    logic              done;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    hsv_word_t hsv_pending[$];
    rgb_word_t rgb_expected[$];
    logic      word_taken = 1'b0;
    int        gap_left = 0;
    int        stall_cycles = 0;
    int        errors = 0;

    hsv_to_rgb_converter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint unsigned round_half_up(longint unsigned num,
                                                      longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic rgb_word_t predict_rgb(hsv_word_t w);
        longint unsigned h;
        longint unsigned r;
        longint unsigned s;
        longint unsigned v;
        longint unsigned p;
        longint unsigned q;
        longint unsigned t;
        sector_t         sec;
        rgb_word_t       c;
        h = longint'(w.hue) % HUE_TURN;
        r = h % HUE_SECTOR;
        s = w.sat;
        v = w.val;
        sec = sector_t'(h / HUE_SECTOR);
        if (s == 0)
        begin
            c.red = CHAN_W'(v);
            c.green = CHAN_W'(v);
            c.blue = CHAN_W'(v);
            return c;
        end
        p = round_half_up(v * (FRAC_ONE - s), FRAC_ONE);
        q = round_half_up(v * (LEVEL_DEN - s * r), LEVEL_DEN);
        t = round_half_up(v * (LEVEL_DEN - s * (HUE_SECTOR - r)), LEVEL_DEN);
        case (sec)
            SEC_RED:
            begin
                c.red = CHAN_W'(v); c.green = CHAN_W'(t); c.blue = CHAN_W'(p);
            end
            SEC_YELLOW:
            begin
                c.red = CHAN_W'(q); c.green = CHAN_W'(v); c.blue = CHAN_W'(p);
            end
            SEC_GREEN:
            begin
                c.red = CHAN_W'(p); c.green = CHAN_W'(v); c.blue = CHAN_W'(t);
            end
            SEC_CYAN:
            begin
                c.red = CHAN_W'(p); c.green = CHAN_W'(q); c.blue = CHAN_W'(v);
            end
            SEC_BLUE:
            begin
                c.red = CHAN_W'(t); c.green = CHAN_W'(p); c.blue = CHAN_W'(v);
            end
            default:
            begin
                c.red = CHAN_W'(v); c.green = CHAN_W'(p); c.blue = CHAN_W'(q);
            end
        endcase
        return c;
    endfunction

    function automatic logic [CHAN_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 8'd1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Driver: a new word is presented only after the previous one was taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || word_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (hsv_pending.size() > TAIL_WORDS && $urandom_range(0, 9) == 0)
            begin
                gap_left <= int'($urandom_range(0, 10));
                start <= 1'b0;
            end
            else if (hsv_pending.size() > 0)
            begin
                hsv_word_t w;
                w = hsv_pending.pop_front();
                start <= 1'b1;
                hue <= w.hue;
                saturation <= w.sat;
                brightness <= w.val;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each result, then records the expectation of a newly taken word.
    always @(posedge clk)
    begin
        hsv_word_t w;
        rgb_word_t exp_c;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (rgb_expected.size() == 0)
                begin
                    $error("unexpected result red=%0d green=%0d blue=%0d", red, green, blue);
                    errors++;
                end
                else
                begin
                    exp_c = rgb_expected.pop_front();
                    if (red !== exp_c.red)
                    begin
                        $error("red: expected %0d, actual %0d", exp_c.red, red);
                        errors++;
                    end
                    if (green !== exp_c.green)
                    begin
                        $error("green: expected %0d, actual %0d", exp_c.green, green);
                        errors++;
                    end
                    if (blue !== exp_c.blue)
                    begin
                        $error("blue: expected %0d, actual %0d", exp_c.blue, blue);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                w.hue = hue;
                w.sat = saturation;
                w.val = brightness;
                rgb_expected = {rgb_expected, predict_rgb(w)};
            end
            word_taken <= start && !busy;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        hsv_word_t w;
        int        base;
        int        hue_edges[$];
        int        level_pairs[$];
        hue_edges = '{0, 1, 3839, 3840, 7679, 7680, 11520, 15360, 19200, 23039,
                      23040, 26880, 65535};
        foreach (hue_edges[i])
        begin
            w.hue = HUE_W'(hue_edges[i]);
            w.sat = 8'd255;
            w.val = 8'd255;
            hsv_pending = {hsv_pending, w};
        end
        // Grey, black, and midpoint levels where rounding halves occur.
        level_pairs = '{0, 255, 255, 0, 0, 0, 1, 1, 128, 127, 255, 1, 1, 255, 200, 77};
        for (int i = 0; i < level_pairs.size(); i += 2)
        begin
            w.hue = 16'd1920 + 16'(i) * 16'd3840;
            w.sat = CHAN_W'(level_pairs[i]);
            w.val = CHAN_W'(level_pairs[i + 1]);
            hsv_pending = {hsv_pending, w};
        end
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                base = int'($urandom_range(0, 17)) * HUE_SECTOR + int'($urandom_range(0, 4));
                w.hue = HUE_W'((base >= 2) ? base - 2 : base);
            end
            else
            begin
                w.hue = HUE_W'($urandom_range(0, 65535));
            end
            w.sat = pick_level();
            w.val = pick_level();
            hsv_pending = {hsv_pending, w};
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (hsv_pending.size() != 0 || start || rgb_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && rgb_expected.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
